// ===== sv/yoc_pkg.sv =====
package yoc_pkg;

   localparam int ANGLE_BITS_DEFAULT = 16;
   localparam int ACCUM_BITS_DEFAULT = 32;

   localparam int CORDIC_STEPS = 24;
   localparam int STEP_BITS    = 5;
   localparam int Z_BITS       = 34;
   localparam int CNT_BITS     = 6;
   localparam int TICK_BITS    = 16;
   localparam int LIMIT_BITS   = 15;
   localparam int GYRO_BITS    = 20;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CNT_BITS-1:0] CNT_MAX = '1;
   localparam logic [31:0] CORDIC_K0 = 32'd652032874;

   localparam logic [TICK_BITS-1:0]  TICK_PERIOD_RESET    = 16'd655;
   localparam logic [LIMIT_BITS-1:0] MISMATCH_LIMIT_RESET = 15'd182;
   localparam logic [LIMIT_BITS-1:0] STILL_LIMIT_RESET    = 15'd104;
   localparam logic [CNT_BITS-1:0]   PERSIST_COUNT_RESET  = 6'd10;
   localparam logic [CNT_BITS-1:0]   AVERAGE_COUNT_RESET  = 6'd20;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_TICK_PERIOD    = 3'd0,
      REG_MISMATCH_LIMIT = 3'd1,
      REG_STILL_LIMIT    = 3'd2,
      REG_PERSIST_COUNT  = 3'd3,
      REG_AVERAGE_COUNT  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic start;
      logic vec_mode;
   } cordic_ctrl_type;

   function automatic logic [31:0] atan_entry(input logic [STEP_BITS-1:0] i);
      logic [31:0] r;
      case (i)
         5'd0:  r = 32'd536870912;
         5'd1:  r = 32'd316933406;
         5'd2:  r = 32'd167458907;
         5'd3:  r = 32'd85004756;
         5'd4:  r = 32'd42667331;
         5'd5:  r = 32'd21354465;
         5'd6:  r = 32'd10679838;
         5'd7:  r = 32'd5340245;
         5'd8:  r = 32'd2670163;
         5'd9:  r = 32'd1335087;
         5'd10: r = 32'd667544;
         5'd11: r = 32'd333772;
         5'd12: r = 32'd166886;
         5'd13: r = 32'd83443;
         5'd14: r = 32'd41721;
         5'd15: r = 32'd20860;
         5'd16: r = 32'd10430;
         5'd17: r = 32'd5215;
         5'd18: r = 32'd2607;
         5'd19: r = 32'd1303;
         5'd20: r = 32'd651;
         5'd21: r = 32'd325;
         5'd22: r = 32'd162;
         5'd23: r = 32'd81;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== sv/yaw_offset_calibrator_core.sv =====
// Yaw offset calibrator. One transaction per control tick: the block takes
// IMU yaw, vision yaw, a vision-valid flag and gyro rate and returns the IMU
// yaw corrected by the learned offset, together with the mismatch, still and
// offset-updated flags. A tick that needs no trigonometry passes S_EXT and
// S_QUAL to S_OUT; a tick that adds unit vectors to the sums or recomputes
// the offset also runs one shared 24-step CORDIC twice in between (sin/cos
// of both yaws, or atan2 of both sums).
// The input side stalls from accept until the result is loaded into the
// output register; a waiting result does not block the next accept.
module yaw_offset_calibrator_core #(
   parameter int ANGLE_BITS = yoc_pkg::ANGLE_BITS_DEFAULT,
   parameter int ACCUM_BITS = yoc_pkg::ACCUM_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [ANGLE_BITS-1:0]          req_imu_yaw,
   input  logic signed [ANGLE_BITS-1:0]          req_vision_yaw,
   input  logic                                  req_vision_available,
   input  logic signed [yoc_pkg::GYRO_BITS-1:0]  req_gyro_rate,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [ANGLE_BITS-1:0]          rsp_calibrated_yaw,
   output logic                                  rsp_mismatch_flag,
   output logic                                  rsp_still_flag,
   output logic                                  rsp_offset_updated,
   input  logic                                  csr_write,
   input  logic [yoc_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [yoc_pkg::CSR_DATA_BITS-1:0]     csr_data
);
   import yoc_pkg::*;

   localparam int DW = ACCUM_BITS + 10;
   localparam int PW = GYRO_BITS + TICK_BITS + 5;
   localparam int CW = ANGLE_BITS + LIMIT_BITS;
   localparam int A  = ANGLE_BITS;

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_EXT     = 8'b0000_0010,
      S_QUAL    = 8'b0000_0100,
      S_ROT_IMU = 8'b0000_1000,
      S_ROT_VIS = 8'b0001_0000,
      S_VEC_VIS = 8'b0010_0000,
      S_VEC_IMU = 8'b0100_0000,
      S_OUT     = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [TICK_BITS-1:0]  tick_period_ff, tick_period_in;
   logic [LIMIT_BITS-1:0] mismatch_limit_ff, mismatch_limit_in;
   logic [LIMIT_BITS-1:0] still_limit_ff, still_limit_in;
   logic [CNT_BITS-1:0]   persist_count_ff, persist_count_in;
   logic [CNT_BITS-1:0]   average_count_ff, average_count_in;

   logic signed [A-1:0]          imu_ff, imu_in, vis_ff, vis_in;
   logic                         avail_ff, avail_in;
   logic signed [GYRO_BITS-1:0]  gyro_ff, gyro_in;
   logic signed [GYRO_BITS+TICK_BITS:0] prod_ff, prod_in;

   logic signed [A-1:0]          offset_ff, offset_in;
   logic signed [A-1:0]          last_vis_ff, last_vis_in;
   logic signed [A-1:0]          ref_ff, ref_in;
   logic [CNT_BITS-1:0]          rest_ff, rest_in;
   logic [CNT_BITS-1:0]          mis_cnt_ff, mis_cnt_in;
   logic [CNT_BITS-1:0]          still_cnt_ff, still_cnt_in;
   logic                         needed_ff, needed_in;
   logic                         slow_ff, slow_in;
   logic signed [ACCUM_BITS-1:0] sic_ff, sic_in, sis_ff, sis_in;
   logic signed [ACCUM_BITS-1:0] svc_ff, svc_in, svs_ff, svs_in;
   logic signed [ACCUM_BITS-1:0] ic_ff, ic_in, is_ff, is_in;
   logic [31:0]                  av_ff, av_in;
   logic                         zero_ff, zero_in;
   logic                         flip_ff, flip_in;
   logic                         upd_ff, upd_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [A-1:0]          rsp_yaw_ff, rsp_yaw_in;
   logic                         rsp_mis_ff, rsp_mis_in;
   logic                         rsp_still_ff, rsp_still_in;
   logic                         rsp_upd_ff, rsp_upd_in;

   cordic_ctrl_type              cordic_ctrl;
   logic signed [DW-1:0]         cx_start, cy_start, cx_result, cy_result;
   logic signed [Z_BITS-1:0]     cz_start, cz_result;
   logic                         cordic_done;

   // qualifier and prep signals
   logic signed [PW-1:0]         ext_sum;
   logic signed [A-1:0]          vis_eff, mis_err, still_err;
   logic [A-1:0]                 mis_abs, still_abs;
   logic                         mis_over, still_under;
   logic [CNT_BITS-1:0]          q_mis_cnt, q_still_cnt;
   logic                         q_needed, q_slow;
   logic signed [A-1:0]          q_ref;
   logic                         go;
   logic signed [A-1:0]          rot_ang;
   logic signed [31:0]           rot_z, rot_zf;
   logic                         rot_flip;
   logic signed [ACCUM_BITS-1:0] vec_cos, vec_sin;
   logic signed [DW-1:0]         vec_x, vec_y;
   logic                         vec_neg, vec_zero;
   logic signed [DW-1:0]         post_x, post_y;
   logic signed [ACCUM_BITS-1:0] unit_c, unit_s;
   logic [31:0]                  ai, diff;
   logic [32:0]                  diff_round;

   function automatic logic [CNT_BITS-1:0] inc_sat(input logic [CNT_BITS-1:0] c);
      return (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
   endfunction

   function automatic logic signed [ACCUM_BITS-1:0] sat_add(
      input logic signed [ACCUM_BITS-1:0] a,
      input logic signed [ACCUM_BITS-1:0] b
   );
      logic signed [ACCUM_BITS:0] s;
      s = (ACCUM_BITS+1)'(a) + (ACCUM_BITS+1)'(b);
      if (s[ACCUM_BITS] != s[ACCUM_BITS-1])
         return s[ACCUM_BITS] ? {1'b1, {(ACCUM_BITS-1){1'b0}}}
                              : {1'b0, {(ACCUM_BITS-1){1'b1}}};
      return s[ACCUM_BITS-1:0];
   endfunction

   yoc_cordic #(
      .DATA_BITS(DW)
   ) u_cordic (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (cordic_ctrl),
      .x_start  (cx_start),
      .y_start  (cy_start),
      .z_start  (cz_start),
      .done     (cordic_done),
      .x_result (cx_result),
      .y_result (cy_result),
      .z_result (cz_result)
   );

   // per-tick qualifier logic, used in S_QUAL
   always_comb begin
      ext_sum = PW'(prod_ff) + PW'(32768);
      vis_eff = (vis_ff == last_vis_ff) ? vis_ff + ext_sum[16 +: A] : vis_ff;

      mis_err  = vis_eff - imu_ff - offset_ff;
      mis_abs  = mis_err[A-1] ? A'(-mis_err) : A'(mis_err);
      mis_over = CW'(mis_abs) > CW'(mismatch_limit_ff);
      q_mis_cnt = mis_over ? inc_sat(mis_cnt_ff) : '0;
      q_needed  = mis_over ? needed_ff : 1'b0;
      if (q_mis_cnt > persist_count_ff) begin
         q_mis_cnt = '0;
         q_needed  = 1'b1;
      end

      still_err   = ref_ff - vis_eff;
      still_abs   = still_err[A-1] ? A'(-still_err) : A'(still_err);
      still_under = CW'(still_abs) < CW'(still_limit_ff);
      q_still_cnt = still_cnt_ff;
      q_ref       = ref_ff;
      q_slow      = slow_ff;
      // stillness qualifier only runs while a mismatch is reported
      if (q_needed) begin
         if (still_under) begin
            q_still_cnt = inc_sat(still_cnt_ff);
         end else begin
            q_still_cnt = '0;
            q_ref       = vis_eff;
            q_slow      = 1'b0;
         end
         if (q_still_cnt > persist_count_ff) begin
            q_still_cnt = '0;
            q_ref       = vis_eff;
            q_slow      = 1'b1;
         end
      end
      go = q_needed && q_slow && avail_ff;
   end

   // CORDIC operand prep and result post-processing
   always_comb begin
      rot_ang  = state_ff[2] ? imu_ff : last_vis_ff;
      rot_z    = $signed({rot_ang, {(32-A){1'b0}}});
      rot_flip = (rot_z > 32'sd1073741824) || (rot_z < -32'sd1073741824);
      rot_zf   = rot_flip ? (rot_z ^ 32'sh8000_0000) : rot_z;

      vec_cos  = state_ff[2] ? svc_ff : sic_ff;
      vec_sin  = state_ff[2] ? svs_ff : sis_ff;
      vec_neg  = vec_cos[ACCUM_BITS-1];
      vec_zero = (vec_cos == '0) && (vec_sin == '0);
      vec_x    = DW'(vec_cos) <<< 8;
      vec_y    = DW'(vec_sin) <<< 8;
      if (vec_neg) begin
         vec_x = -vec_x;
         vec_y = -vec_y;
      end

      post_x = (cx_result + DW'(32768)) >>> 16;
      post_y = (cy_result + DW'(32768)) >>> 16;
      if (flip_ff) begin
         post_x = -post_x;
         post_y = -post_y;
      end
      unit_c = ACCUM_BITS'(post_x);
      unit_s = ACCUM_BITS'(post_y);

      ai         = zero_ff ? 32'd0 : cz_result[31:0];
      diff       = av_ff - ai;
      diff_round = ({1'b0, diff} + (33'd1 << (31 - A))) >> (32 - A);
   end

   always_comb begin
      state_in          = state_ff;
      tick_period_in    = tick_period_ff;
      mismatch_limit_in = mismatch_limit_ff;
      still_limit_in    = still_limit_ff;
      persist_count_in  = persist_count_ff;
      average_count_in  = average_count_ff;
      imu_in   = imu_ff;
      vis_in   = vis_ff;
      avail_in = avail_ff;
      gyro_in  = gyro_ff;
      prod_in  = prod_ff;
      offset_in    = offset_ff;
      last_vis_in  = last_vis_ff;
      ref_in       = ref_ff;
      rest_in      = rest_ff;
      mis_cnt_in   = mis_cnt_ff;
      still_cnt_in = still_cnt_ff;
      needed_in    = needed_ff;
      slow_in      = slow_ff;
      sic_in = sic_ff;
      sis_in = sis_ff;
      svc_in = svc_ff;
      svs_in = svs_ff;
      ic_in  = ic_ff;
      is_in  = is_ff;
      av_in  = av_ff;
      zero_in = zero_ff;
      flip_in = flip_ff;
      upd_in  = upd_ff;
      cordic_ctrl = '0;
      cx_start = DW'($signed({1'b0, CORDIC_K0}));
      cy_start = '0;
      cz_start = Z_BITS'(rot_zf);
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_yaw_in   = rsp_yaw_ff;
      rsp_mis_in   = rsp_mis_ff;
      rsp_still_in = rsp_still_ff;
      rsp_upd_in   = rsp_upd_ff;

      if (csr_write) begin
         case (csr_index)
            REG_TICK_PERIOD:    tick_period_in    = csr_data[TICK_BITS-1:0];
            REG_MISMATCH_LIMIT: mismatch_limit_in = csr_data[LIMIT_BITS-1:0];
            REG_STILL_LIMIT:    still_limit_in    = csr_data[LIMIT_BITS-1:0];
            REG_PERSIST_COUNT:  persist_count_in  = csr_data[CNT_BITS-1:0];
            REG_AVERAGE_COUNT:  average_count_in  = csr_data[CNT_BITS-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               imu_in   = req_imu_yaw;
               vis_in   = req_vision_yaw;
               avail_in = req_vision_available;
               gyro_in  = req_gyro_rate;
               state_in = S_EXT;
            end
         end
         S_EXT: begin
            prod_in  = gyro_ff * $signed({1'b0, tick_period_ff});
            state_in = S_QUAL;
         end
         S_QUAL: begin
            last_vis_in  = vis_eff;
            mis_cnt_in   = q_mis_cnt;
            needed_in    = q_needed;
            still_cnt_in = q_still_cnt;
            ref_in       = q_ref;
            slow_in      = q_slow;
            upd_in       = 1'b0;
            if (go && (rest_ff > average_count_ff)) begin
               cordic_ctrl = '{start: 1'b1, vec_mode: 1'b1};
               cx_start = vec_x;
               cy_start = vec_y;
               cz_start = vec_neg ? Z_BITS'(33'h0_8000_0000) : '0;
               zero_in  = vec_zero;
               state_in = S_VEC_VIS;
            end else if (go) begin
               cordic_ctrl = '{start: 1'b1, vec_mode: 1'b0};
               flip_in  = rot_flip;
               state_in = S_ROT_IMU;
            end else begin
               rest_in  = '0;
               sic_in   = '0;
               sis_in   = '0;
               svc_in   = '0;
               svs_in   = '0;
               state_in = S_OUT;
            end
         end
         S_ROT_IMU: begin
            if (cordic_done) begin
               ic_in = unit_c;
               is_in = unit_s;
               cordic_ctrl = '{start: 1'b1, vec_mode: 1'b0};
               flip_in  = rot_flip;
               state_in = S_ROT_VIS;
            end
         end
         S_ROT_VIS: begin
            if (cordic_done) begin
               sic_in  = sat_add(sic_ff, ic_ff);
               sis_in  = sat_add(sis_ff, is_ff);
               svc_in  = sat_add(svc_ff, unit_c);
               svs_in  = sat_add(svs_ff, unit_s);
               rest_in = inc_sat(rest_ff);
               state_in = S_OUT;
            end
         end
         S_VEC_VIS: begin
            if (cordic_done) begin
               av_in = zero_ff ? 32'd0 : cz_result[31:0];
               cordic_ctrl = '{start: 1'b1, vec_mode: 1'b1};
               cx_start = vec_x;
               cy_start = vec_y;
               cz_start = vec_neg ? Z_BITS'(33'h0_8000_0000) : '0;
               zero_in  = vec_zero;
               state_in = S_VEC_IMU;
            end
         end
         S_VEC_IMU: begin
            if (cordic_done) begin
               offset_in = diff_round[A-1:0];
               rest_in   = '0;
               upd_in    = 1'b1;
               state_in  = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_yaw_in   = imu_ff + offset_ff;
               rsp_mis_in   = needed_ff;
               rsp_still_in = slow_ff;
               rsp_upd_in   = upd_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         tick_period_ff    <= TICK_PERIOD_RESET;
         mismatch_limit_ff <= MISMATCH_LIMIT_RESET;
         still_limit_ff    <= STILL_LIMIT_RESET;
         persist_count_ff  <= PERSIST_COUNT_RESET;
         average_count_ff  <= AVERAGE_COUNT_RESET;
         offset_ff    <= '0;
         last_vis_ff  <= '0;
         ref_ff       <= '0;
         rest_ff      <= '0;
         mis_cnt_ff   <= '0;
         still_cnt_ff <= '0;
         needed_ff    <= 1'b0;
         slow_ff      <= 1'b0;
         sic_ff       <= '0;
         sis_ff       <= '0;
         svc_ff       <= '0;
         svs_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff          <= state_in;
         tick_period_ff    <= tick_period_in;
         mismatch_limit_ff <= mismatch_limit_in;
         still_limit_ff    <= still_limit_in;
         persist_count_ff  <= persist_count_in;
         average_count_ff  <= average_count_in;
         offset_ff    <= offset_in;
         last_vis_ff  <= last_vis_in;
         ref_ff       <= ref_in;
         rest_ff      <= rest_in;
         mis_cnt_ff   <= mis_cnt_in;
         still_cnt_ff <= still_cnt_in;
         needed_ff    <= needed_in;
         slow_ff      <= slow_in;
         sic_ff       <= sic_in;
         sis_ff       <= sis_in;
         svc_ff       <= svc_in;
         svs_ff       <= svs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      imu_ff   <= imu_in;
      vis_ff   <= vis_in;
      avail_ff <= avail_in;
      gyro_ff  <= gyro_in;
      prod_ff  <= prod_in;
      ic_ff    <= ic_in;
      is_ff    <= is_in;
      av_ff    <= av_in;
      zero_ff  <= zero_in;
      flip_ff  <= flip_in;
      upd_ff   <= upd_in;
      rsp_yaw_ff   <= rsp_yaw_in;
      rsp_mis_ff   <= rsp_mis_in;
      rsp_still_ff <= rsp_still_in;
      rsp_upd_ff   <= rsp_upd_in;
   end

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_calibrated_yaw = rsp_yaw_ff;
   assign rsp_mismatch_flag  = rsp_mis_ff;
   assign rsp_still_flag     = rsp_still_ff;
   assign rsp_offset_updated = rsp_upd_ff;

endmodule

// ===== sv/yoc_cordic.sv =====
module yoc_cordic #(
   parameter int DATA_BITS = yoc_pkg::ACCUM_BITS_DEFAULT + 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  yoc_pkg::cordic_ctrl_type          ctrl,
   input  logic signed [DATA_BITS-1:0]       x_start,
   input  logic signed [DATA_BITS-1:0]       y_start,
   input  logic signed [yoc_pkg::Z_BITS-1:0] z_start,
   output logic                              done,
   output logic signed [DATA_BITS-1:0]       x_result,
   output logic signed [DATA_BITS-1:0]       y_result,
   output logic signed [yoc_pkg::Z_BITS-1:0] z_result
);
   import yoc_pkg::*;

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic                        vec_ff, vec_in;
   logic [STEP_BITS-1:0]        step_ff, step_in;
   logic signed [DATA_BITS-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [Z_BITS-1:0]    z_ff, z_in;
   logic signed [DATA_BITS-1:0] x_shift, y_shift;
   logic signed [Z_BITS-1:0]    angle;
   logic                        sigma;

   always_comb begin
      x_shift = x_ff >>> step_ff;
      y_shift = y_ff >>> step_ff;
      angle   = $signed(Z_BITS'(atan_entry(step_ff)));
      // rotation mode follows the residual angle, vectoring drives y to zero
      sigma   = vec_ff ? y_ff[DATA_BITS-1] : !z_ff[Z_BITS-1];

      busy_in = busy_ff;
      done_in = 1'b0;
      vec_in  = vec_ff;
      step_in = step_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         vec_in  = ctrl.vec_mode;
         step_in = '0;
         x_in    = x_start;
         y_in    = y_start;
         z_in    = z_start;
      end else if (busy_ff) begin
         if (sigma) begin
            x_in = x_ff - y_shift;
            y_in = y_ff + x_shift;
            z_in = z_ff - angle;
         end else begin
            x_in = x_ff + y_shift;
            y_in = y_ff - x_shift;
            z_in = z_ff + angle;
         end
         if (step_ff == STEP_BITS'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
         vec_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
         vec_ff  <= vec_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign done     = done_ff;
   assign x_result = x_ff;
   assign y_result = y_ff;
   assign z_result = z_ff;

endmodule

// ===== sv/yoc_checker.sv =====
module yoc_checker #(
   parameter int ANGLE_BITS = yoc_pkg::ANGLE_BITS_DEFAULT
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic signed [ANGLE_BITS-1:0] rsp_calibrated_yaw,
   input logic                         rsp_mismatch_flag,
   input logic                         rsp_still_flag,
   input logic                         rsp_offset_updated
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_calibrated_yaw))
      else $error("stalled result transaction dropped or changed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled while transaction in work");

   a_update_needs_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_offset_updated |-> rsp_mismatch_flag && rsp_still_flag)
      else $error("offset update without mismatch and still flags");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result or busy survives reset");

endmodule

bind yaw_offset_calibrator_core yoc_checker #(
   .ANGLE_BITS(ANGLE_BITS)
) u_yoc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_calibrated_yaw (rsp_calibrated_yaw),
   .rsp_mismatch_flag  (rsp_mismatch_flag),
   .rsp_still_flag     (rsp_still_flag),
   .rsp_offset_updated (rsp_offset_updated)
);
